@@ src/godp_pkg.sv @@
// ----------------------------------------------------------------------------
// godp_pkg
// shared constants, tables and types of the gray ordered dither packer:
// dither matrix, contrast gain and brightness offset tables, register map
// ----------------------------------------------------------------------------
package godp_pkg;

    localparam int DITHER_W   = 16;
    localparam int DITHER_H   = 16;
    localparam int COL_W      = $clog2(DITHER_W);
    localparam int ROW_W      = $clog2(DITHER_H);
    localparam int LANES      = 8;
    localparam int PIX_W      = 8;
    localparam int CNT_W      = 4;
    localparam int FRAC_W     = 16;
    localparam int GAIN_W     = 18;
    localparam int OFFS_W     = 25;
    localparam int PROD_W     = 29;
    localparam int SUM_W      = 27;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // register select on word address bit
    localparam logic REG_CONTRAST   = 1'b0;
    localparam logic REG_BRIGHTNESS = 1'b1;

    typedef logic [PIX_W-1:0]          pix_t;
    typedef logic [GAIN_W-1:0]         gain_t;
    typedef logic signed [OFFS_W-1:0]  offs_t;
    typedef pix_t  rom_t  [256];
    typedef gain_t gain_tbl_t [256];
    typedef offs_t offs_tbl_t [256];

    localparam rom_t BASE_MATRIX = '{
        8'h91,8'hB9,8'hB1,8'h89,8'h6B,8'h43,8'h4B,8'h73,
        8'h93,8'hBB,8'hB3,8'h8B,8'h69,8'h41,8'h49,8'h71,
        8'hC1,8'hF1,8'hE9,8'hA1,8'h3B,8'h0B,8'h13,8'h5B,
        8'hC3,8'hF3,8'hEB,8'hA3,8'h39,8'h09,8'h11,8'h59,
        8'hC9,8'hF9,8'hE1,8'hA9,8'h33,8'h03,8'h1B,8'h53,
        8'hCB,8'hFB,8'hE3,8'hAB,8'h31,8'h01,8'h19,8'h51,
        8'h99,8'hD9,8'hD1,8'h81,8'h63,8'h23,8'h2B,8'h7B,
        8'h9B,8'hDB,8'hD3,8'h83,8'h61,8'h21,8'h29,8'h79,
        8'h6C,8'h44,8'h4C,8'h74,8'h94,8'hBC,8'hB4,8'h8C,
        8'h6E,8'h46,8'h4E,8'h76,8'h96,8'hBE,8'hB6,8'h8E,
        8'h3C,8'h0C,8'h14,8'h5C,8'hC4,8'hF4,8'hEC,8'hA4,
        8'h3E,8'h0E,8'h16,8'h5E,8'hC6,8'hF6,8'hEE,8'hA6,
        8'h34,8'h04,8'h1C,8'h54,8'hCC,8'hFC,8'hE4,8'hAC,
        8'h36,8'h06,8'h1E,8'h56,8'hCE,8'hFE,8'hE6,8'hAE,
        8'h64,8'h24,8'h2C,8'h7C,8'h9C,8'hDC,8'hD4,8'h84,
        8'h66,8'h26,8'h2E,8'h7E,8'h9E,8'hDE,8'hD6,8'h86,
        8'h92,8'hBA,8'hB2,8'h8A,8'h68,8'h40,8'h48,8'h70,
        8'h90,8'hB8,8'hB0,8'h88,8'h6A,8'h42,8'h4A,8'h72,
        8'hC2,8'hF2,8'hEA,8'hA2,8'h38,8'h08,8'h10,8'h58,
        8'hC0,8'hF0,8'hE8,8'hA0,8'h3A,8'h0A,8'h12,8'h5A,
        8'hCA,8'hFA,8'hE2,8'hAA,8'h30,8'h00,8'h18,8'h50,
        8'hC8,8'hF8,8'hE0,8'hA8,8'h32,8'h02,8'h1A,8'h52,
        8'h9A,8'hDA,8'hD2,8'h82,8'h60,8'h20,8'h28,8'h78,
        8'h98,8'hD8,8'hD0,8'h80,8'h62,8'h22,8'h2A,8'h7A,
        8'h6F,8'h47,8'h4F,8'h77,8'h97,8'hBF,8'hB7,8'h8F,
        8'h6D,8'h45,8'h4D,8'h75,8'h95,8'hBD,8'hB5,8'h8D,
        8'h3F,8'h0F,8'h17,8'h5F,8'hC7,8'hF7,8'hEF,8'hA7,
        8'h3D,8'h0D,8'h15,8'h5D,8'hC5,8'hF5,8'hED,8'hA5,
        8'h37,8'h07,8'h1F,8'h57,8'hCF,8'hFE,8'hE7,8'hAF,
        8'h35,8'h05,8'h1D,8'h55,8'hCD,8'hFD,8'hE5,8'hAD,
        8'h67,8'h27,8'h2F,8'h7F,8'h9F,8'hDF,8'hD7,8'h87,
        8'h65,8'h25,8'h2D,8'h7D,8'h9D,8'hDD,8'hD5,8'h85
    };

    function automatic rom_t build_dither_rom();
        rom_t r;
        for (int i = 0; i < 256; i++)
        begin
            r[i] = 8'hFF - BASE_MATRIX[i];
        end
        return r;
    endfunction

    // gain in q16: round((c*c + 300c + 40000) * 65536 / 40000)
    function automatic gain_tbl_t build_gain_tbl();
        gain_tbl_t t;
        longint    c;
        longint    num;
        for (int i = 0; i < 256; i++)
        begin
            c    = (i < 128) ? longint'(i) : longint'(i) - 256;
            num  = c * c + 300 * c + 40000;
            t[i] = GAIN_W'((num * 65536 + 20000) / 40000);
        end
        return t;
    endfunction

    // offset in q16: 1.275 * b * 65536, rounded half away from zero
    function automatic offs_tbl_t build_offs_tbl();
        offs_tbl_t t;
        longint    b;
        longint    q;
        for (int i = 0; i < 256; i++)
        begin
            b    = (i < 128) ? longint'(i) : longint'(i) - 256;
            q    = (((b < 0) ? -b : b) * 835584 + 5) / 10;
            t[i] = OFFS_W'((b < 0) ? -q : q);
        end
        return t;
    endfunction

    localparam rom_t      DITHER_ROM = build_dither_rom();
    localparam gain_tbl_t GAIN_TBL   = build_gain_tbl();
    localparam offs_tbl_t OFFS_TBL   = build_offs_tbl();

endpackage

@@ src/gray_ordered_dither_packer_core.sv @@
// ----------------------------------------------------------------------------
// gray_ordered_dither_packer_core
// eight gray pixels in, one packed byte of ordered-dither halftone out
// ----------------------------------------------------------------------------
// Takes one request of eight 8-bit gray pixels per clock while in_stall is
// low and returns one packed byte per request, first pixel in bit 7, via the
// input register, then the result register. Eight parallel lanes each apply
// the contrast gain (one 10x19 multiply), the brightness offset and the
// 16x16 dither threshold in a single pass, so a request can follow every
// cycle unless stalled; the row and column phase counters are updated at
// acceptance. Contrast and brightness are written over the APB port at byte
// addresses 0 and 4; the user must write them only while the block is idle,
// not enforced here; gain and offset are looked up on write, held in registers.
// ----------------------------------------------------------------------------
module gray_ordered_dither_packer_core
    import godp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        pix0,
    input  logic [7:0]        pix1,
    input  logic [7:0]        pix2,
    input  logic [7:0]        pix3,
    input  logic [7:0]        pix4,
    input  logic [7:0]        pix5,
    input  logic [7:0]        pix6,
    input  logic [7:0]        pix7,
    input  logic [3:0]        valid_count,
    input  logic              line_end,
    input  logic              page_start,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        packed_bits,
    output logic              line_end_out
);

    logic [7:0]       contrast_reg;
    logic [7:0]       brightness_reg;
    gain_t            gain_reg;
    offs_t            offs_reg;
    logic             cfg_write;

    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] phase_reg;
    logic [ROW_W-1:0] row_cur;
    logic [COL_W-1:0] phase_cur;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] phase_next;
    logic [COL_W:0]   phase_sum;

    logic             s1_valid_reg;
    pix_t             s1_pix_reg [LANES];
    logic [CNT_W-1:0] s1_cnt_reg;
    logic             s1_line_end_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_phase_reg;

    logic             out_valid_reg;
    logic [7:0]       packed_reg;
    logic             line_end_out_reg;
    logic [7:0]       packed_next;

    logic             in_take;
    logic             s1_move;
    pix_t             in_pix [LANES];
    logic [CNT_W-1:0] cnt_clamped;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_CONTRAST:   prdata = {{(DATA_W-8){1'b0}}, contrast_reg};
            REG_BRIGHTNESS: prdata = {{(DATA_W-8){1'b0}}, brightness_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contrast_reg   <= '0;
            brightness_reg <= '0;
            gain_reg       <= GAIN_TBL[0];
            offs_reg       <= OFFS_TBL[0];
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_CONTRAST)
            begin
                contrast_reg <= pwdata[7:0];
                gain_reg     <= GAIN_TBL[pwdata[7:0]];
            end
            else
            begin
                brightness_reg <= pwdata[7:0];
                offs_reg       <= OFFS_TBL[pwdata[7:0]];
            end
        end
    end

    // handshake
    assign s1_move  = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = s1_valid_reg & ~s1_move;
    assign in_take  = in_valid & ~in_stall;

    assign in_pix[0] = pix0;
    assign in_pix[1] = pix1;
    assign in_pix[2] = pix2;
    assign in_pix[3] = pix3;
    assign in_pix[4] = pix4;
    assign in_pix[5] = pix5;
    assign in_pix[6] = pix6;
    assign in_pix[7] = pix7;

    assign cnt_clamped = (valid_count > CNT_W'(LANES)) ? CNT_W'(LANES) : valid_count;

    // row and column phase
    always_comb
    begin
        row_cur   = page_start ? '0 : row_reg;
        phase_cur = page_start ? '0 : phase_reg;
        phase_sum = {1'b0, phase_cur} + (COL_W+1)'(LANES);
        if (line_end)
        begin
            row_next   = (row_cur == ROW_W'(DITHER_H-1)) ? '0 : row_cur + 1'b1;
            phase_next = '0;
        end
        else
        begin
            row_next   = row_cur;
            phase_next = (phase_sum >= (COL_W+1)'(DITHER_W))
                       ? COL_W'(phase_sum - (COL_W+1)'(DITHER_W))
                       : phase_sum[COL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            phase_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                row_reg   <= row_next;
                phase_reg <= phase_next;
            end
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_pix_reg      <= in_pix;
            s1_cnt_reg      <= cnt_clamped;
            s1_line_end_reg <= line_end;
            s1_row_reg      <= row_cur;
            s1_phase_reg    <= phase_cur;
        end
    end

    // per-lane transfer curve and threshold
    always_comb
    begin
        logic signed [9:0]        diff;
        logic signed [PROD_W-1:0] x;
        logic [7:0]               t_c;
        logic signed [SUM_W-1:0]  y;
        logic [7:0]               t_b;
        logic [COL_W:0]           col_sum;
        logic [COL_W-1:0]         col;
        logic [7:0]               d;
        logic [8:0]               s;
        packed_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            diff = $signed({2'b00, s1_pix_reg[i]}) - 10'sd128;
            x    = PROD_W'(diff) * $signed({{(PROD_W-GAIN_W){1'b0}}, gain_reg})
                 + PROD_W'(128 << FRAC_W);
            if (x < 0)
                t_c = 8'd0;
            else if (x >= PROD_W'(255 << FRAC_W))
                t_c = 8'd255;
            else
                t_c = x[FRAC_W+7:FRAC_W];

            y = $signed({{(SUM_W-8-FRAC_W){1'b0}}, t_c, {FRAC_W{1'b0}}})
              + SUM_W'(offs_reg);
            if (y < 0)
                t_b = 8'd0;
            else if (y >= SUM_W'(255 << FRAC_W))
                t_b = 8'd255;
            else
                t_b = y[FRAC_W+7:FRAC_W];

            col_sum = {1'b0, s1_phase_reg} + (COL_W+1)'(i);
            col     = (col_sum >= (COL_W+1)'(DITHER_W))
                    ? COL_W'(col_sum - (COL_W+1)'(DITHER_W))
                    : col_sum[COL_W-1:0];
            d       = DITHER_ROM[{s1_row_reg[3:0], col[3:0]}];
            s       = {1'b0, t_b} + {1'b0, d};
            packed_next[LANES-1-i] = s[8] & (CNT_W'(i) < s1_cnt_reg);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move)
            out_valid_reg <= 1'b1;
        else if (~out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            packed_reg       <= packed_next;
            line_end_out_reg <= s1_line_end_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign packed_bits  = packed_reg;
    assign line_end_out = line_end_out_reg;

endmodule
